FILE: hdl/rwdc_pkg.sv
// Shared types and constants for the ray wall distance caster.
package rwdc_pkg;
  localparam int CoordW = 11;
  localparam int OrgW   = 19;
  localparam int TrigW  = 16;
  localparam int DistW  = 20;
  localparam logic [DistW-1:0] DistMax = '1;
  localparam logic signed [TrigW-1:0] CordicStart = 16'sd9949;
  localparam logic OpLoad = 1'b0;
  localparam logic OpCast = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
  } wall_t;

  function automatic logic [31:0] atan_step(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0: r = 32'd536870912;
      4'd1: r = 32'd316933406;
      4'd2: r = 32'd167458907;
      4'd3: r = 32'd85004756;
      4'd4: r = 32'd42667331;
      4'd5: r = 32'd21354465;
      4'd6: r = 32'd10679838;
      4'd7: r = 32'd5340245;
      4'd8: r = 32'd2670163;
      4'd9: r = 32'd1335087;
      4'd10: r = 32'd667544;
      4'd11: r = 32'd333772;
      4'd12: r = 32'd166886;
      4'd13: r = 32'd83443;
      4'd14: r = 32'd41722;
      default: r = 32'd20861;
    endcase
    return r;
  endfunction
endpackage

FILE: hdl/rwdc_cordic.sv
// Iterative 16-step CORDIC that turns a heading into cosine and sine.
module rwdc_cordic import rwdc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [15:0]             heading,
  output logic                    done,
  output logic signed [TrigW-1:0] cos_o,
  output logic signed [TrigW-1:0] sin_o
);
  logic signed [TrigW-1:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [3:0] i_r;
  logic busy_r, flip_r, done_r;
  logic [15:0] h_fold;
  logic flip;
  logic signed [TrigW-1:0] xs, ys;

  assign flip   = heading[15] ^ heading[14];
  assign h_fold = flip ? heading + 16'h8000 : heading;
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= 4'd0;
        flip_r <= flip;
        x_r    <= CordicStart;
        y_r    <= '0;
        z_r    <= {{2{h_fold[15]}}, h_fold, 16'd0};
      end else if (busy_r) begin
        if (!z_r[33]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - $signed({2'b00, atan_step(i_r)});
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + $signed({2'b00, atan_step(i_r)});
        end
        i_r <= i_r + 4'd1;
        if (i_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;
endmodule

FILE: hdl/rwdc_divider.sv
// Restoring divider giving floor(nt * 16384 / det), saturated to the distance width.
module rwdc_divider import rwdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [46:0]       num,
  input  logic [37:0]       den,
  output logic              done,
  output logic [DistW-1:0]  quot
);
  // Quotient bits above DistW only saturate; test num >= den << DistW first.
  logic [38:0] rem_r;
  logic [46:0] num_r;
  logic [DistW-1:0] q_r;
  logic [4:0] cnt_r;
  logic busy_r, done_r, sat_r;
  logic [38:0] trial;
  logic [38:0] shifted;

  assign shifted = {rem_r[37:0], num_r[46]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        sat_r  <= ({11'd0, num} >= {den, 20'd0});
        rem_r  <= {12'd0, num[46:20]};
        num_r  <= {num[19:0], 27'd0};
        cnt_r  <= 5'd0;
        q_r    <= '0;
      end else if (busy_r) begin
        if (!trial[38]) begin
          rem_r <= trial;
          q_r   <= {q_r[DistW-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[DistW-2:0], 1'b0};
        end
        num_r <= {num_r[45:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DistW-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = sat_r ? DistMax : q_r;
endmodule

FILE: hdl/ray_wall_distance_caster_top.sv
// Top level of the ray wall distance caster: wall memory, scan sequencer and result register.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | operation, wall slot, endpoints, origin, heading
//  out_    | output    | out_valid / out_ready | distance, hit, nearest_wall
//  cfg_    | input     | cfg_valid / cfg_ready | wall_count
//
// A load item writes the wall memory in the cycle it is accepted and yields no result.
// A cast runs the CORDIC, then reads, multiplies and compares each examined wall in turn
// (memory read, products, compare), then runs the divider when a wall was hit, and then
// moves the result into the output register. The walls examined are the first wall_count
// slots, with wall_count capped at MAX_WALLS.
// Reset is synchronous and active low; it clears control state and wall_count to zero.
// in_ready is high while the sequencer is idle. A finished cast waits in its last state
// while an earlier result is still held on the output, so no item can enter behind it.
module ray_wall_distance_caster_top import rwdc_pkg::*; #(
  parameter int MAX_WALLS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [3:0]        in_wall_slot,
  input  logic signed [10:0] in_seg_start_x,
  input  logic signed [10:0] in_seg_start_y,
  input  logic signed [10:0] in_seg_end_x,
  input  logic signed [10:0] in_seg_end_y,
  input  logic signed [18:0] in_origin_x,
  input  logic signed [18:0] in_origin_y,
  input  logic [15:0]       in_heading,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [19:0]       out_distance,
  output logic              out_hit,
  output logic [3:0]        out_nearest_wall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_wall_count
);
  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);

  typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_READ, S_MUL, S_CMP, S_DIV, S_OUT} state_t;

  wall_t mem [MAX_WALLS];
  wall_t rd_r;

  state_t state_r;
  logic [4:0] wall_count_r;
  logic [CW-1:0] idx_r, limit_r;
  logic signed [18:0] ox_r, oy_r;
  logic signed [TrigW-1:0] cs_r, sn_r;
  logic signed [36:0] det_r, nt_r, nu_r;
  logic found_r;
  logic [36:0] best_nt_r, best_det_r;
  logic [7:0] best_r;
  logic res_hit_r;
  logic out_valid_r, out_hit_r;
  logic [19:0] out_dist_r;
  logic [3:0] out_wall_r;
  logic cordic_start, cordic_done, div_start, div_done;
  logic signed [TrigW-1:0] cs_w, sn_w;
  logic [19:0] quot;
  logic in_acc;
  logic slot_ok;
  logic [CW-1:0] limit;
  logic found_nxt_any;
  logic take;
  logic signed [11:0] wx, wy;
  logic signed [28:0] px, py;
  logic signed [27:0] cs_wy, sn_wx;
  logic signed [31:0] px_wy, py_wx;
  logic signed [34:0] sn_px, cs_py;
  logic signed [36:0] det_a, nt_a, nu_a;
  logic hit_ok;
  logic [58:0] lhs, rhs;
  logic [46:0] div_num;
  logic [36:0] div_nt, div_det;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cordic_start = in_acc && (in_operation == OpCast);
  assign slot_ok = ({28'd0, in_wall_slot} < 32'(MAX_WALLS));
  assign limit = ({27'd0, wall_count_r} > 32'(MAX_WALLS)) ? CW'(MAX_WALLS)
                                                          : CW'(wall_count_r);

  // Wall memory: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OpLoad && slot_ok)
      mem[AW'(in_wall_slot)] <= '{in_seg_start_x, in_seg_start_y, in_seg_end_x, in_seg_end_y};
    rd_r <= mem[AW'(idx_r)];
  end

  rwdc_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cordic_start), .heading(in_heading),
    .done(cordic_done), .cos_o(cs_w), .sin_o(sn_w));

  assign div_start = (state_r == S_CMP) && (idx_r + CW'(1) >= limit_r) && found_nxt_any;

  assign wx = 12'(rd_r.ex) - 12'(rd_r.sx);
  assign wy = 12'(rd_r.ey) - 12'(rd_r.sy);
  assign px = (29'(rd_r.sx) <<< 8) - 29'(ox_r);
  assign py = (29'(rd_r.sy) <<< 8) - 29'(oy_r);

  // Cross products of one wall. The offsets fit in 20 bits and the wall vector in 12,
  // so each product is narrow; the sums stay well inside 37 bits.
  assign cs_wy = 28'(cs_r) * 28'(wy);
  assign sn_wx = 28'(sn_r) * 28'(wx);
  assign px_wy = 32'(px) * 32'(wy);
  assign py_wx = 32'(py) * 32'(wx);
  assign sn_px = 35'(sn_r) * 35'(px);
  assign cs_py = 35'(cs_r) * 35'(py);
  assign det_a = 37'(cs_wy) - 37'(sn_wx);
  assign nt_a  = 37'(px_wy) - 37'(py_wx);
  assign nu_a  = 37'(sn_px) - 37'(cs_py);

  // After sign normalization a hit has 0 < det < 2^26 and 0 <= nt < 2^32, so the
  // nearer test needs only two 32x27 products.
  assign hit_ok = (det_r != '0) && !nu_r[36] && !nt_r[36]
                  && ({8'd0, nu_r} <= {det_r, 8'd0});
  assign lhs  = 59'(nt_r[31:0]) * 59'(best_det_r[26:0]);
  assign rhs  = 59'(best_nt_r[31:0]) * 59'(det_r[26:0]);
  assign take = hit_ok && (!found_r || lhs < rhs);
  assign found_nxt_any = found_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wall_count_r <= '0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) wall_count_r <= cfg_wall_count;
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cordic_start) begin
            ox_r    <= in_origin_x;
            oy_r    <= in_origin_y;
            limit_r <= limit;
            idx_r   <= '0;
            found_r <= 1'b0;
            best_r  <= '0;
            state_r <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cordic_done) begin
            cs_r <= cs_w;
            sn_r <= sn_w;
            if (limit_r == '0) begin
              res_hit_r <= 1'b0;
              state_r   <= S_OUT;
            end else state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_MUL;
        S_MUL: begin
          if (det_a[36]) begin
            det_r <= -det_a; nt_r <= -nt_a; nu_r <= -nu_a;
          end else begin
            det_r <= det_a; nt_r <= nt_a; nu_r <= nu_a;
          end
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (take) begin
            found_r    <= 1'b1;
            best_nt_r  <= nt_r;
            best_det_r <= det_r;
            best_r     <= 8'(idx_r);
          end
          if (idx_r + CW'(1) >= limit_r) begin
            if (found_nxt_any) state_r <= S_DIV;
            else begin
              res_hit_r <= 1'b0;
              state_r   <= S_OUT;
            end
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_READ;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_hit_r <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          // The divider output and the best entry hold still until the next cast.
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= res_hit_r;
            out_dist_r  <= res_hit_r ? quot : DistMax;
            out_wall_r  <= res_hit_r ? best_r[3:0] : 4'd0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign div_nt  = take ? nt_r : best_nt_r;
  assign div_det = take ? det_r : best_det_r;
  assign div_num = {div_nt[32:0], 14'd0};

  rwdc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den({1'b0, div_det}), .done(div_done), .quot(quot));

  assign out_valid        = out_valid_r;
  assign out_distance     = out_dist_r;
  assign out_hit          = out_hit_r;
  assign out_nearest_wall = out_wall_r;
endmodule
